// File: sv/scds_pkg.sv
// Shared types, constants and the prescaler table for the serial clock divider search.
`default_nettype none

package scds_pkg;

  localparam int REQ_W   = 32;
  localparam int CLK_W   = 32;
  localparam int RATE_W  = 30;
  localparam int PRESC_W = 3;
  localparam int DIV_W   = 4;
  localparam int SHIFT_W = 4;

  localparam int PRESC_CODES = 8;
  localparam int DIV_CODES   = 16;
  localparam int CAND_W      = $clog2(PRESC_CODES * DIV_CODES);

  // divisor (d + 1) is 1..16, remainder stays below it
  localparam int M_W   = DIV_W + 1;
  localparam int REM_W = DIV_W;

  localparam int DIV_BITS_PER_STAGE = 3;
  localparam int DIV_STAGES         = RATE_W / DIV_BITS_PER_STAGE;

  localparam int SCDS_QUEUE_DEPTH = 2;

  localparam logic [PRESC_W-1:0] FALLBACK_PRESC = 3'd7;
  localparam logic [DIV_W-1:0]   FALLBACK_DIV   = 4'd15;
  localparam logic [CLK_W-1:0]   CLK_RESET      = 32'd100000000;

  typedef struct packed {
    logic             bad;
    logic [REQ_W-1:0] rate;
  } req_item_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [PRESC_W-1:0] presc;
    logic [DIV_W-1:0]   div;
  } cand_tag_t;

  typedef struct packed {
    logic               bad_request;
    logic [PRESC_W-1:0] prescaler_select;
    logic [DIV_W-1:0]   divider_select;
    logic [RATE_W-1:0]  achieved_rate;
  } result_t;

  // Right shift that divides by 2 * prescaler divisor (all divisors are powers of two).
  function automatic logic [SHIFT_W-1:0] presc_shift(input logic [PRESC_W-1:0] code);
    logic [SHIFT_W-1:0] sh;
    case (code)
      3'd0:    sh = 4'd2;
      3'd1:    sh = 4'd3;
      3'd2:    sh = 4'd4;
      3'd3:    sh = 4'd7;
      3'd4:    sh = 4'd8;
      3'd5:    sh = 4'd11;
      3'd6:    sh = 4'd12;
      default: sh = 4'd13;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

// File: sv/scds_front.sv
// Front end: accept requests, flag zero requests, and queue them for the search engine.
`default_nettype none

module scds_front #(
  parameter int QUEUE_DEPTH = scds_pkg::SCDS_QUEUE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [scds_pkg::REQ_W-1:0] in_requested_rate,
  output logic                          q_valid,
  output scds_pkg::req_item_t           q_item,
  input  wire logic                     q_pop
);
  import scds_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             pop;
  req_item_t        push_item;

  assign in_stall = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_valid && q_pop;

  // classify on the way in
  assign push_item.bad  = (in_requested_rate == '0);
  assign push_item.rate = in_requested_rate;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: sv/scds_div_pipe.sv
// Pipelined restoring divider: 30-bit dividend by a 1..16 divisor, three quotient bits per stage.
`default_nettype none

module scds_div_pipe (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire scds_pkg::cand_tag_t        in_tag,
  input  wire logic [scds_pkg::RATE_W-1:0] in_num,
  input  wire logic [scds_pkg::M_W-1:0]    in_m,
  output scds_pkg::cand_tag_t             out_tag,
  output logic [scds_pkg::RATE_W-1:0]      out_quot
);
  import scds_pkg::*;

  cand_tag_t         tag_r [DIV_STAGES];
  logic [RATE_W-1:0] num_r [DIV_STAGES];
  logic [REM_W-1:0]  rem_r [DIV_STAGES];
  logic [M_W-1:0]    m_r   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    cand_tag_t         tag_in;
    logic [RATE_W-1:0] num_in;
    logic [REM_W-1:0]  rem_in;
    logic [M_W-1:0]    m_in;
    logic [RATE_W-1:0] num_out;
    logic [REM_W-1:0]  rem_out;

    if (s == 0) begin : g_head
      assign tag_in = in_tag;
      assign num_in = in_num;
      assign rem_in = '0;
      assign m_in   = in_m;
    end else begin : g_body
      assign tag_in = tag_r[s-1];
      assign num_in = num_r[s-1];
      assign rem_in = rem_r[s-1];
      assign m_in   = m_r[s-1];
    end

    // num holds remaining dividend bits on top, quotient bits shift in at the bottom
    always_comb begin
      logic [M_W-1:0] trial;
      logic           qbit;
      rem_out = rem_in;
      num_out = num_in;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        trial = {rem_out, num_out[RATE_W-1]};
        qbit  = (trial >= m_in);
        if (qbit) begin
          trial = trial - m_in;
        end
        rem_out = trial[REM_W-1:0];
        num_out = {num_out[RATE_W-2:0], qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s] <= '0;
      end else begin
        tag_r[s] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      num_r[s] <= num_out;
      rem_r[s] <= rem_out;
      m_r[s]   <= m_in;
    end
  end

  assign out_tag  = tag_r[DIV_STAGES-1];
  assign out_quot = num_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: sv/scds_search.sv
// Back end: issue all prescaler/divider candidates, keep the best rate, and hand out results.
`default_nettype none

module scds_search (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [scds_pkg::CLK_W-1:0]    clk_hz,
  input  wire logic                          q_valid,
  input  wire scds_pkg::req_item_t           q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_bad_request,
  output logic [scds_pkg::PRESC_W-1:0]       out_prescaler_select,
  output logic [scds_pkg::DIV_W-1:0]         out_divider_select,
  output logic [scds_pkg::RATE_W-1:0]        out_achieved_rate
);
  import scds_pkg::*;

  logic               busy_r, busy_nxt;
  logic               issuing_r, issuing_nxt;
  logic [CAND_W-1:0]  cnt_r, cnt_nxt;
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [RATE_W-1:0]  best_rate_r, best_rate_nxt;
  logic [PRESC_W-1:0] best_p_r, best_p_nxt;
  logic [DIV_W-1:0]   best_d_r, best_d_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  result_t            hold_r, hold_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r, out_nxt;

  logic [PRESC_W-1:0] iss_p;
  logic [DIV_W-1:0]   iss_d;
  logic [CLK_W-1:0]   iss_shifted;
  logic [M_W-1:0]     iss_m;
  cand_tag_t          iss_tag;
  cand_tag_t          pq_tag;
  logic [RATE_W-1:0]  pq_quot;

  logic               start;
  logic               hit;
  logic               fin;
  logic               move;
  logic [RATE_W-1:0]  upd_rate;
  logic [PRESC_W-1:0] upd_p;
  logic [DIV_W-1:0]   upd_d;

  // candidate index: prescaler code on top, divider code below
  assign iss_p       = cnt_r[CAND_W-1 -: PRESC_W];
  assign iss_d       = cnt_r[DIV_W-1:0];
  assign iss_shifted = clk_hz >> presc_shift(iss_p);
  assign iss_m       = {1'b0, iss_d} + M_W'(1);

  assign iss_tag.valid = issuing_r;
  assign iss_tag.last  = (cnt_r == '1);
  assign iss_tag.presc = iss_p;
  assign iss_tag.div   = iss_d;

  scds_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (iss_tag),
    .in_num   (iss_shifted[RATE_W-1:0]),
    .in_m     (iss_m),
    .out_tag  (pq_tag),
    .out_quot (pq_quot)
  );

  assign start = q_valid && !busy_r && !hold_valid_r;
  assign q_pop = start;

  assign hit = pq_tag.valid && (REQ_W'(pq_quot) <= req_r) && (pq_quot > best_rate_r);
  assign fin = pq_tag.valid && pq_tag.last;

  assign upd_rate = hit ? pq_quot      : best_rate_r;
  assign upd_p    = hit ? pq_tag.presc : best_p_r;
  assign upd_d    = hit ? pq_tag.div   : best_d_r;

  assign move = hold_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    busy_nxt       = busy_r;
    issuing_nxt    = issuing_r;
    cnt_nxt        = cnt_r;
    req_nxt        = req_r;
    best_rate_nxt  = best_rate_r;
    best_p_nxt     = best_p_r;
    best_d_nxt     = best_d_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    if (move) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = hold_r;
      hold_valid_nxt = 1'b0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (start) begin
      if (q_item.bad) begin
        hold_valid_nxt = 1'b1;
        hold_nxt       = '0;
        hold_nxt.bad_request = 1'b1;
      end else begin
        busy_nxt      = 1'b1;
        issuing_nxt   = 1'b1;
        cnt_nxt       = '0;
        req_nxt       = q_item.rate;
        best_rate_nxt = '0;
        best_p_nxt    = FALLBACK_PRESC;
        best_d_nxt    = FALLBACK_DIV;
      end
    end

    if (issuing_r) begin
      cnt_nxt = cnt_r + CAND_W'(1);
      if (cnt_r == '1) begin
        issuing_nxt = 1'b0;
      end
    end

    if (pq_tag.valid) begin
      best_rate_nxt = upd_rate;
      best_p_nxt    = upd_p;
      best_d_nxt    = upd_d;
    end

    // last candidate is the fallback pair, so its quotient is the fallback rate
    if (fin) begin
      busy_nxt                  = 1'b0;
      hold_valid_nxt            = 1'b1;
      hold_nxt.bad_request      = 1'b0;
      hold_nxt.prescaler_select = upd_p;
      hold_nxt.divider_select   = upd_d;
      hold_nxt.achieved_rate    = (upd_rate == '0) ? pq_quot : upd_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      issuing_r    <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      issuing_r    <= issuing_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    req_r       <= req_nxt;
    best_rate_r <= best_rate_nxt;
    best_p_r    <= best_p_nxt;
    best_d_r    <= best_d_nxt;
    hold_r      <= hold_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_bad_request      = out_r.bad_request;
  assign out_prescaler_select = out_r.prescaler_select;
  assign out_divider_select   = out_r.divider_select;
  assign out_achieved_rate    = out_r.achieved_rate;

`ifndef SYNTH
  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (busy_r && !hold_valid_r))
    else $error("search finished without a free hold slot");

  a_issue_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    issuing_r |-> busy_r)
    else $error("candidate issued outside a search");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bad_request) |->
      (out_r.achieved_rate == '0 && out_r.prescaler_select == '0 &&
       out_r.divider_select == '0))
    else $error("rejected request carries nonzero fields");

  a_pop_takes: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (busy_r || hold_valid_r))
    else $error("popped request was dropped");
`endif

endmodule

`default_nettype wire

// File: sv/spi_clock_divider_search_top.sv
// Top level of the serial clock divider search: config register, front queue and search engine.
`default_nettype none

// Serial clock divider search.
// Input channel (in_valid / in_stall / in_requested_rate): one transfer carries a requested
//   serial clock rate in hertz. A zero request is flagged and answered without a search.
// Result channel (out_valid / out_stall / out_*): one transfer per request, in request order,
//   carrying the chosen prescaler code, divider code and the achieved rate.
// Config port: cfg_we writes cfg_input_clock_hz into the input clock register at the edge.
//   Write it only while no request is in flight.
// Path: a nonzero request leaves the queue, the engine issues the 128 prescaler/divider
//   candidates one per cycle, drains the 10-stage divider pipeline, then the result moves
//   into the hold register and then into the output register that drives out_valid. A zero
//   request goes from the queue into the hold register and on to the output register.
// Search spacing: the next search starts only after the previous one has finished and its
//   result has left the hold register, so searches do not overlap in the divider pipeline.
// Queueing: a 2-entry request queue (QUEUE_DEPTH) decouples input from the search, and a hold
//   register plus the output register let the next search run while a result waits.
// Reset: rst_n (synchronous, active low) empties the queue, aborts any search, drops pending
//   results and loads the input clock register with 100 MHz.
// Stall: while out_stall is high the output register holds its transfer; the engine finishes
//   into the hold register and waits, and in_stall rises once the queue fills.
module spi_clock_divider_search_top #(
  parameter int QUEUE_DEPTH = scds_pkg::SCDS_QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [scds_pkg::CLK_W-1:0]    cfg_input_clock_hz,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [scds_pkg::REQ_W-1:0]    in_requested_rate,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_bad_request,
  output logic [scds_pkg::PRESC_W-1:0]       out_prescaler_select,
  output logic [scds_pkg::DIV_W-1:0]         out_divider_select,
  output logic [scds_pkg::RATE_W-1:0]        out_achieved_rate
);
  import scds_pkg::*;

  logic [CLK_W-1:0] clk_hz_r;
  logic             q_valid;
  req_item_t        q_item;
  logic             q_pop;

  // input clock frequency register, reset to 100 MHz
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_RESET;
    end else if (cfg_we) begin
      clk_hz_r <= cfg_input_clock_hz;
    end
  end

  // accept and classify requests, hold them until the search engine is free
  scds_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_requested_rate (in_requested_rate),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop)
  );

  // sweep all 128 candidate pairs and deliver the best one
  scds_search u_search (
    .clk                  (clk),
    .rst_n                (rst_n),
    .clk_hz               (clk_hz_r),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_bad_request      (out_bad_request),
    .out_prescaler_select (out_prescaler_select),
    .out_divider_select   (out_divider_select),
    .out_achieved_rate    (out_achieved_rate)
  );

endmodule

`default_nettype wire
